/* src/rsst_pkg.sv */
// shared types for the range sum segment tree: opcodes, controller states, command and status
package rsst_pkg;

    localparam int IDX_W = 10;
    localparam int SUM_W = 32;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_BUILD = 2'd1,
        OP_ADD   = 2'd2,
        OP_QUERY = 2'd3
    } t_op;

    typedef enum logic [8:0] {
        S_CLEAR   = 9'b000000001,
        S_IDLE    = 9'b000000010,
        S_BUILD_L = 9'b000000100,
        S_BUILD_R = 9'b000001000,
        S_BUILD_W = 9'b000010000,
        S_UPD_RD  = 9'b000100000,
        S_UPD_WR  = 9'b001000000,
        S_Q_LO    = 9'b010000000,
        S_Q_HI    = 9'b100000000
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic bld_init;
        logic bld_rd_l;
        logic bld_rd_r;
        logic bld_wr;
        logic upd_init;
        logic upd_rd;
        logic upd_wr;
        logic q_init;
        logic q_lo;
        logic q_hi;
        logic emit_bad;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic idx_ok;
        logic reversed;
        logic node_last;
        logic lo_lt_hi;
    } t_stat;

endpackage

/* src/rsst_ram.sv */
// generic single write port ram with one registered read port
module rsst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/rsst_dp.sv */
// datapath: node store, walk counters, accumulator and result register
module rsst_dp #(
    parameter int LEAVES = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  rsst_pkg::t_cmd                     i_cmd,
    input  logic [rsst_pkg::IDX_W-1:0]         i_index,
    input  logic [rsst_pkg::IDX_W-1:0]         i_last_index,
    input  logic [rsst_pkg::SUM_W-1:0]         i_value,
    output rsst_pkg::t_stat                    o_stat,
    output logic [rsst_pkg::SUM_W-1:0]         o_range_sum,
    output logic                               o_bad_range,
    output logic                               o_valid
);

    localparam int DEPTH = 2 * LEAVES;
    localparam int AW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);
    localparam logic [31:0] LV = 32'(LEAVES);

    logic [AW-1:0]                r_clr;
    logic [NW-1:0]                r_node;
    logic [NW-1:0]                r_lo;
    logic [NW-1:0]                r_hi;
    logic [rsst_pkg::SUM_W-1:0]   r_acc;
    logic [rsst_pkg::SUM_W-1:0]   r_val;
    logic                         r_pend;
    logic [rsst_pkg::SUM_W-1:0]   r_sum;
    logic                         r_bad;
    logic                         r_valid;

    logic                         w_we;
    logic [AW-1:0]                w_waddr;
    logic [rsst_pkg::SUM_W-1:0]   w_wdata;
    logic [AW-1:0]                w_raddr;
    logic [rsst_pkg::SUM_W-1:0]   w_rdata;
    logic [rsst_pkg::SUM_W-1:0]   w_acc_sum;
    logic [NW:0]                  w_dbl_l;
    logic [NW:0]                  w_dbl_r;
    logic [NW-1:0]                w_hi_m1;
    logic [31:0]                  w_first;
    logic [31:0]                  w_last;

    rsst_ram #(
        .WIDTH (rsst_pkg::SUM_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_dbl_l   = {r_node, 1'b0};
    assign w_dbl_r   = {r_node, 1'b1};
    assign w_hi_m1   = r_hi - NW'(1);
    assign w_acc_sum = r_acc + (r_pend ? w_rdata : '0);
    assign w_first   = (32'(i_index) > LV - 32'd1) ? LV - 32'd1 : 32'(i_index);
    assign w_last    = (32'(i_last_index) > LV - 32'd1) ? LV - 32'd1 : 32'(i_last_index);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = '0;
        if (i_cmd.clr_step) begin
            w_we    = 1'b1;
            w_waddr = r_clr;
        end else if (i_cmd.load) begin
            w_we    = 1'b1;
            w_waddr = AW'(32'(i_index) + LV);
            w_wdata = i_value;
        end else if (i_cmd.bld_wr) begin
            w_we    = 1'b1;
            w_waddr = r_node[AW-1:0];
            w_wdata = r_acc + w_rdata;
        end else if (i_cmd.upd_wr) begin
            w_we    = 1'b1;
            w_waddr = r_node[AW-1:0];
            w_wdata = w_rdata + r_val;
        end
    end

    always_comb begin
        w_raddr = '0;
        if (i_cmd.bld_rd_l) begin
            w_raddr = w_dbl_l[AW-1:0];
        end else if (i_cmd.bld_rd_r) begin
            w_raddr = w_dbl_r[AW-1:0];
        end else if (i_cmd.upd_rd) begin
            w_raddr = r_node[AW-1:0];
        end else if (i_cmd.q_lo) begin
            w_raddr = r_lo[AW-1:0];
        end else if (i_cmd.q_hi) begin
            w_raddr = w_hi_m1[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.bld_init) begin
                r_node <= NW'(LV - 32'd1);
            end
            if (i_cmd.bld_rd_r) begin
                r_acc <= w_rdata;
            end
            if (i_cmd.bld_wr) begin
                r_node <= r_node - NW'(1);
            end
            if (i_cmd.upd_init) begin
                r_node <= NW'(32'(i_index) + LV);
                r_val  <= i_value;
            end
            if (i_cmd.upd_wr) begin
                r_node <= r_node >> 1;
            end
            if (i_cmd.q_init) begin
                r_lo   <= NW'(w_first + LV);
                r_hi   <= NW'(w_last + LV + 32'd1);
                r_acc  <= '0;
                r_pend <= 1'b0;
            end
            if (i_cmd.q_lo) begin
                r_acc <= w_acc_sum;
                if (o_stat.lo_lt_hi) begin
                    r_pend <= r_lo[0];
                    if (r_lo[0]) begin
                        r_lo <= r_lo + NW'(1);
                    end
                end else begin
                    r_pend  <= 1'b0;
                    r_sum   <= w_acc_sum;
                    r_bad   <= 1'b0;
                    r_valid <= 1'b1;
                end
            end
            if (i_cmd.q_hi) begin
                r_acc  <= w_acc_sum;
                r_pend <= r_hi[0];
                r_lo   <= r_lo >> 1;
                r_hi   <= r_hi >> 1;
            end
            if (i_cmd.emit_bad) begin
                r_sum   <= '0;
                r_bad   <= 1'b1;
                r_valid <= 1'b1;
            end
        end
    end

    assign o_stat.clr_last  = (r_clr == AW'(DEPTH - 1));
    assign o_stat.idx_ok    = (32'(i_index) < LV);
    assign o_stat.reversed  = (i_index > i_last_index);
    assign o_stat.node_last = (r_node == NW'(1));
    assign o_stat.lo_lt_hi  = (r_lo < r_hi);

    assign o_range_sum = r_sum;
    assign o_bad_range = r_bad;
    assign o_valid     = r_valid;

endmodule

/* src/rsst_ctrl.sv */
// controller state machine sequencing clear, load, build, update and query
module rsst_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  logic [1:0]      i_op,
    input  rsst_pkg::t_stat i_stat,
    output rsst_pkg::t_cmd  o_cmd,
    output logic            busy
);

    rsst_pkg::t_state r_state;
    rsst_pkg::t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            rsst_pkg::S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = rsst_pkg::S_IDLE;
                end
            end
            rsst_pkg::S_IDLE: begin
                if (start) begin
                    unique case (rsst_pkg::t_op'(i_op))
                        rsst_pkg::OP_LOAD: begin
                            o_cmd.load = i_stat.idx_ok;
                        end
                        rsst_pkg::OP_BUILD: begin
                            o_cmd.bld_init = 1'b1;
                            n_state        = rsst_pkg::S_BUILD_L;
                        end
                        rsst_pkg::OP_ADD: begin
                            if (i_stat.idx_ok) begin
                                o_cmd.upd_init = 1'b1;
                                n_state        = rsst_pkg::S_UPD_RD;
                            end
                        end
                        rsst_pkg::OP_QUERY: begin
                            if (i_stat.reversed) begin
                                o_cmd.emit_bad = 1'b1;
                            end else begin
                                o_cmd.q_init = 1'b1;
                                n_state      = rsst_pkg::S_Q_LO;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            rsst_pkg::S_BUILD_L: begin
                o_cmd.bld_rd_l = 1'b1;
                n_state        = rsst_pkg::S_BUILD_R;
            end
            rsst_pkg::S_BUILD_R: begin
                o_cmd.bld_rd_r = 1'b1;
                n_state        = rsst_pkg::S_BUILD_W;
            end
            rsst_pkg::S_BUILD_W: begin
                o_cmd.bld_wr = 1'b1;
                n_state      = i_stat.node_last ? rsst_pkg::S_IDLE : rsst_pkg::S_BUILD_L;
            end
            rsst_pkg::S_UPD_RD: begin
                o_cmd.upd_rd = 1'b1;
                n_state      = rsst_pkg::S_UPD_WR;
            end
            rsst_pkg::S_UPD_WR: begin
                o_cmd.upd_wr = 1'b1;
                n_state      = i_stat.node_last ? rsst_pkg::S_IDLE : rsst_pkg::S_UPD_RD;
            end
            rsst_pkg::S_Q_LO: begin
                o_cmd.q_lo = 1'b1;
                n_state    = i_stat.lo_lt_hi ? rsst_pkg::S_Q_HI : rsst_pkg::S_IDLE;
            end
            rsst_pkg::S_Q_HI: begin
                o_cmd.q_hi = 1'b1;
                n_state    = rsst_pkg::S_Q_LO;
            end
            default: begin
                n_state = rsst_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rsst_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != rsst_pkg::S_IDLE);

endmodule

/* src/range_sum_segment_tree.sv */
// top level of the range sum segment tree: controller plus datapath
//
// A command word is taken at a rising edge with start high and busy low.
// i_op selects load leaf, build inner nodes, add delta to a leaf and its
// ancestors, or range sum query over i_index..i_last_index inclusive.
// Only a query yields a result word: o_range_sum and o_bad_range are valid
// for the single cycle in which o_valid is high; the receiver cannot stall.
// Load, an out of range load or add, and a reversed query keep busy low;
// a reversed query answers zero with o_bad_range set in the next cycle.
// Add walks the leaf-to-root path, reading and then writing each node.
// Query walks both bounds up the tree, one store read per cycle; the result
// shows in the first cycle with busy low. Build reads the left child, then
// the right child, then writes each inner node, from LEAVES-1 down to 1.
// The single read port of the node store sets the pace of these walks.
// After reset the whole store is zeroed one word per cycle with busy high.
module range_sum_segment_tree #(
    parameter int LEAVES = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_op,
    input  logic [rsst_pkg::IDX_W-1:0]        i_index,
    input  logic [rsst_pkg::IDX_W-1:0]        i_last_index,
    input  logic signed [rsst_pkg::SUM_W-1:0] i_value,
    output logic                              o_valid,
    output logic signed [rsst_pkg::SUM_W-1:0] o_range_sum,
    output logic                              o_bad_range
);

    rsst_pkg::t_cmd              w_cmd;
    rsst_pkg::t_stat             w_stat;
    logic [rsst_pkg::SUM_W-1:0]  w_sum;

    rsst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_op    (i_op),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .busy    (busy)
    );

    rsst_dp #(
        .LEAVES (LEAVES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_index      (i_index),
        .i_last_index (i_last_index),
        .i_value      (i_value),
        .o_stat       (w_stat),
        .o_range_sum  (w_sum),
        .o_bad_range  (o_bad_range),
        .o_valid      (o_valid)
    );

    assign o_range_sum = w_sum;

endmodule

/* tb/sv/tb.sv */
// testbench for range_sum_segment_tree: directed and random command words checked against a tree predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEAVES = 1024;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_WORDS = 880;
    localparam int IDX_W = rsst_pkg::IDX_W;
    localparam int SUM_W = rsst_pkg::SUM_W;

    typedef struct {
        rsst_pkg::t_op           op;
        logic [IDX_W-1:0]        lo_leaf;
        logic [IDX_W-1:0]        hi_leaf;
        logic signed [SUM_W-1:0] value;
        int                      gap;
    } t_tree_word;

    typedef struct {
        logic [IDX_W-1:0]        lo_leaf;
        logic [IDX_W-1:0]        hi_leaf;
        logic signed [SUM_W-1:0] sum;
        logic                    bad;
    } t_span_result;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [1:0]              i_op = rsst_pkg::OP_LOAD;
    logic [IDX_W-1:0]        i_index = '0;
    logic [IDX_W-1:0]        i_last_index = '0;
    logic signed [SUM_W-1:0] i_value = '0;
    logic                    o_valid;
    logic signed [SUM_W-1:0] o_range_sum;
    logic                    o_bad_range;

    t_tree_word   feed_q[$];
    t_span_result pending_sums[$];
    t_tree_word   live_word;
    logic [SUM_W-1:0] node_sum [0:2*LEAVES-1];
    int  hold_cnt = 0;
    int  fault_cnt = 0;
    int  idle_cnt = 0;
    bit  no_gaps = 1'b0;

    range_sum_segment_tree #(.LEAVES(LEAVES)) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_op         (i_op),
        .i_index      (i_index),
        .i_last_index (i_last_index),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .o_range_sum  (o_range_sum),
        .o_bad_range  (o_bad_range)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [SUM_W-1:0] span_sum(int unsigned lo_leaf, int unsigned hi_leaf);
        int unsigned lo;
        int unsigned hi;
        logic [SUM_W-1:0] acc;
        lo = lo_leaf + LEAVES;
        hi = hi_leaf + LEAVES + 1;
        acc = '0;
        while (lo < hi) begin
            if (lo[0]) begin
                acc += node_sum[lo];
                lo++;
            end
            if (hi[0]) begin
                hi--;
                acc += node_sum[hi];
            end
            lo >>= 1;
            hi >>= 1;
        end
        return acc;
    endfunction

    function automatic void apply_word(t_tree_word w);
        t_span_result r;
        int n;
        case (w.op)
            rsst_pkg::OP_LOAD: begin
                node_sum[w.lo_leaf + LEAVES] = w.value;
            end
            rsst_pkg::OP_BUILD: begin
                for (n = LEAVES - 1; n >= 1; n--)
                    node_sum[n] = node_sum[2*n] + node_sum[2*n+1];
            end
            rsst_pkg::OP_ADD: begin
                for (n = w.lo_leaf + LEAVES; n != 0; n >>= 1)
                    node_sum[n] = node_sum[n] + w.value;
            end
            default: begin
                r.lo_leaf = w.lo_leaf;
                r.hi_leaf = w.hi_leaf;
                if (w.lo_leaf > w.hi_leaf) begin
                    r.sum = '0;
                    r.bad = 1'b1;
                end else begin
                    r.sum = span_sum(32'(w.lo_leaf), 32'(w.hi_leaf));
                    r.bad = 1'b0;
                end
                pending_sums.push_back(r);
            end
        endcase
    endfunction

    function automatic void push_word(rsst_pkg::t_op op, int unsigned lo_leaf,
                                      int unsigned hi_leaf, logic [SUM_W-1:0] value);
        t_tree_word w;
        w.op = op;
        w.lo_leaf = IDX_W'(lo_leaf);
        w.hi_leaf = IDX_W'(hi_leaf);
        w.value = value;
        w.gap = no_gaps ? 0 : int'($urandom_range(0, 19));
        feed_q.push_back(w);
    endfunction

    function automatic int unsigned pick_leaf();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return LEAVES - 1;
            default: return $urandom_range(0, LEAVES - 1);
        endcase
    endfunction

    function automatic logic [SUM_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '1;
            3: return '0;
            4: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    function automatic void push_random_query();
        int unsigned a;
        int unsigned b;
        int unsigned t;
        a = $urandom_range(0, LEAVES - 1);
        b = $urandom_range(0, LEAVES - 1);
        case ($urandom_range(0, 9))
            0: begin a = 0; b = LEAVES - 1; end
            1: a = 0;
            2: b = LEAVES - 1;
            3: b = a;
            4: begin
                a = $urandom_range(1, LEAVES - 1);
                b = $urandom_range(0, a - 1);
            end
            default: begin
                if (a > b) begin
                    t = a;
                    a = b;
                    b = t;
                end
            end
        endcase
        push_word(rsst_pkg::OP_QUERY, a, b, $urandom);
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            hold_cnt = 0;
        end else begin
            if (start && !busy)
                apply_word(live_word);
            if (!start || !busy) begin
                if (feed_q.size() != 0 && hold_cnt >= feed_q[0].gap) begin
                    live_word = feed_q.pop_front();
                    start <= 1'b1;
                    i_op <= live_word.op;
                    i_index <= live_word.lo_leaf;
                    i_last_index <= live_word.hi_leaf;
                    i_value <= live_word.value;
                    hold_cnt = 0;
                end else begin
                    start <= 1'b0;
                    if (feed_q.size() != 0)
                        hold_cnt++;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_span_result r;
        if (i_rst_n && o_valid) begin
            if (pending_sums.size() == 0) begin
                fault_cnt++;
                if (fault_cnt <= 10)
                    $display("unexpected result word: sum %0d bad %0b",
                             o_range_sum, o_bad_range);
            end else begin
                r = pending_sums.pop_front();
                if (o_range_sum !== r.sum || o_bad_range !== r.bad) begin
                    fault_cnt++;
                    if (fault_cnt <= 10)
                        $display("query %0d..%0d: expected sum %0d bad %0b, got %0d %0b",
                                 r.lo_leaf, r.hi_leaf, r.sum, r.bad,
                                 o_range_sum, o_bad_range);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid)
            idle_cnt <= 0;
        else if (idle_cnt >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else
            idle_cnt <= idle_cnt + 1;
    end

    initial begin
        for (int n = 0; n < 2 * LEAVES; n++)
            node_sum[n] = '0;
        no_gaps = ($urandom_range(0, 1) != 0);

        // cleared store, add before build, edge leaves and wrap
        push_word(rsst_pkg::OP_QUERY, 0, LEAVES - 1, 0);
        push_word(rsst_pkg::OP_ADD, 5, 0, 7);
        push_word(rsst_pkg::OP_QUERY, 0, LEAVES - 1, 0);
        push_word(rsst_pkg::OP_LOAD, 0, LEAVES - 1, 32'h7FFF_FFFF);
        push_word(rsst_pkg::OP_LOAD, LEAVES - 1, 0, 32'h8000_0000);
        push_word(rsst_pkg::OP_LOAD, 512, 3, '1);
        push_word(rsst_pkg::OP_LOAD, 1, 0, 1);
        push_word(rsst_pkg::OP_QUERY, 0, 0, 0);
        push_word(rsst_pkg::OP_QUERY, LEAVES - 1, LEAVES - 1, 0);
        push_word(rsst_pkg::OP_BUILD, 0, 0, $urandom);
        push_word(rsst_pkg::OP_QUERY, 0, LEAVES - 1, 0);
        push_word(rsst_pkg::OP_QUERY, 0, 511, 0);
        push_word(rsst_pkg::OP_QUERY, 512, LEAVES - 1, 0);
        push_word(rsst_pkg::OP_QUERY, 1, LEAVES - 2, 0);
        push_word(rsst_pkg::OP_ADD, 0, 0, 32'h8000_0000);
        push_word(rsst_pkg::OP_ADD, LEAVES - 1, 0, 32'h7FFF_FFFF);
        push_word(rsst_pkg::OP_ADD, 700, 0, -5);
        push_word(rsst_pkg::OP_QUERY, LEAVES - 1, 0, 0);
        push_word(rsst_pkg::OP_QUERY, 5, 4, 0);
        push_word(rsst_pkg::OP_QUERY, 0, LEAVES - 1, 0);
        push_word(rsst_pkg::OP_LOAD, 3, 0, 100);
        push_word(rsst_pkg::OP_QUERY, 0, LEAVES - 1, 0);
        push_word(rsst_pkg::OP_QUERY, 3, 3, 0);

        for (int k = 0; k < RANDOM_WORDS; k++) begin
            int r;
            if (k % 60 == 0)
                no_gaps = ($urandom_range(0, 2) == 0);
            r = $urandom_range(0, 99);
            if (r < 2)
                push_word(rsst_pkg::OP_BUILD, $urandom, $urandom, $urandom);
            else if (r < 30)
                push_word(rsst_pkg::OP_LOAD, pick_leaf(), $urandom, pick_value());
            else if (r < 55)
                push_word(rsst_pkg::OP_ADD, pick_leaf(), $urandom, pick_value());
            else
                push_random_query();
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (feed_q.size() != 0 || start || busy || pending_sums.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (pending_sums.size() != 0)
            fault_cnt++;
        if (fault_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
